// File: hdl/ugpb_pkg.sv
// Shared types and constants for the uniform grid particle binning block.
// Used by the interfaces, controller, datapath and top level.
`timescale 1ns / 1ps
`default_nettype none

package ugpb_pkg;

    localparam int MAX_PARTICLES = 4096;
    localparam int MAX_GRID_SIDE = 64;

    localparam int PID_W  = 12;
    localparam int CELL_W = 12;
    localparam int CNT_W  = 13;
    localparam int SIDE_W = 7;
    localparam int INV_W  = 15;
    localparam int POS_W  = 16;
    localparam int PROD_W = POS_W + INV_W;
    localparam int BIN_SH = 24;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [INV_W-1:0]  INV_RST   = INV_W'(13187);
    localparam logic [SIDE_W-1:0] GRID_RST  = SIDE_W'(52);
    localparam logic [CNT_W-1:0]  PCOUNT_RST = CNT_W'(4096);

    localparam logic [1:0] REG_INV    = 2'd0;
    localparam logic [1:0] REG_GRID   = 2'd1;
    localparam logic [1:0] REG_PCOUNT = 2'd2;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_BUILD = 2'd1,
        CMD_CELL  = 2'd2,
        CMD_SLOT  = 2'd3
    } t_cmd_code;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_NOT_BUILT = 2'd1,
        STS_RANGE     = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_CNT_RD,
        ST_CNT_CELL,
        ST_CNT_WR,
        ST_PRE_RD,
        ST_PRE_WR,
        ST_SCT_RD,
        ST_SCT_CELL,
        ST_SCT_WR,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_state phase;
        logic   accept;
        logic   s1_adv;
    } t_dp_cmd;

    typedef struct packed {
        logic s1_build;
        logic last_cell;
        logic last_part;
        logic no_part;
    } t_dp_sts;

    function automatic logic [SIDE_W-1:0] clamp_bin(input logic [SIDE_W-1:0] b,
                                                    input logic [SIDE_W-1:0] side);
        clamp_bin = (b >= side) ? side - SIDE_W'(1) : b;
    endfunction

endpackage

`default_nettype wire

// File: hdl/ugpb_in_if.sv
// Input request channel: valid/ready handshake with one request payload.
// Depends on ugpb_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface ugpb_in_if
    import ugpb_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [1:0]        command;
    logic [PID_W-1:0]  particle_id;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [CELL_W-1:0] cell_index;
    logic [PID_W-1:0]  slot_index;

    modport source (output valid, command, particle_id, pos_x, pos_y, cell_index,
                    slot_index, input ready);
    modport sink   (input valid, command, particle_id, pos_x, pos_y, cell_index,
                    slot_index, output ready);
endinterface

`default_nettype wire

// File: hdl/ugpb_out_if.sv
// Result channel: valid/ready handshake with one result payload.
// Depends on ugpb_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface ugpb_out_if
    import ugpb_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] cell_start;
    logic [CNT_W-1:0] cell_end;
    logic [PID_W-1:0] particle_out;
    logic [1:0]       status;

    modport source (output valid, cell_start, cell_end, particle_out, status,
                    input ready);
    modport sink   (input valid, cell_start, cell_end, particle_out, status,
                    output ready);
endinterface

`default_nettype wire

// File: hdl/ugpb_ctrl.sv
// Controller: handshake stages and the build sequencer state machine.
// Depends on ugpb_pkg; drives ugpb_dp through t_dp_cmd.
`timescale 1ns / 1ps
`default_nettype none

module ugpb_ctrl
    import ugpb_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    output logic         o_out_valid,
    input  wire logic    i_out_ready,
    output t_dp_cmd      o_cmd,
    input  wire t_dp_sts i_sts
);

    t_state r_state, n_state;
    logic   r_s1_vld, n_s1_vld;
    logic   r_o_vld, n_o_vld;
    logic   s1_hold, s1_adv, in_ready, accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_s1_vld <= 1'b0;
            r_o_vld  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_s1_vld <= n_s1_vld;
            r_o_vld  <= n_o_vld;
        end
    end

    always_comb begin
        s1_hold  = i_sts.s1_build && (r_state != ST_DONE);
        s1_adv   = r_s1_vld && !s1_hold && (!r_o_vld || i_out_ready);
        in_ready = (r_state == ST_IDLE) && (!r_s1_vld || s1_adv);
        accept   = i_in_valid && in_ready;
        n_s1_vld = accept ? 1'b1 : (s1_adv ? 1'b0 : r_s1_vld);
        n_o_vld  = s1_adv ? 1'b1 : (i_out_ready ? 1'b0 : r_o_vld);
        n_state  = r_state;
        case (r_state)
            ST_IDLE:     if (r_s1_vld && i_sts.s1_build) n_state = ST_CLEAR;
            ST_CLEAR:    if (i_sts.last_cell) n_state = i_sts.no_part ? ST_PRE_RD : ST_CNT_RD;
            ST_CNT_RD:   n_state = ST_CNT_CELL;
            ST_CNT_CELL: n_state = ST_CNT_WR;
            ST_CNT_WR:   n_state = i_sts.last_part ? ST_PRE_RD : ST_CNT_RD;
            ST_PRE_RD:   n_state = ST_PRE_WR;
            ST_PRE_WR: begin
                if (i_sts.last_cell) n_state = i_sts.no_part ? ST_DONE : ST_SCT_RD;
                else n_state = ST_PRE_RD;
            end
            ST_SCT_RD:   n_state = ST_SCT_CELL;
            ST_SCT_CELL: n_state = ST_SCT_WR;
            ST_SCT_WR:   n_state = i_sts.last_part ? ST_DONE : ST_SCT_RD;
            ST_DONE:     if (s1_adv) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
        o_cmd.phase  = r_state;
        o_cmd.accept = accept;
        o_cmd.s1_adv = s1_adv;
        o_in_ready   = in_ready;
        o_out_valid  = r_o_vld;
    end

`ifndef SYNTHESIS
    a_build_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> (r_s1_vld && i_sts.s1_build))
        else $error("build running without its request in stage 1");
    a_s1_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && !s1_adv) |=> r_s1_vld)
        else $error("stage 1 request lost");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |=> !accept)
        else $error("request accepted during build");
`endif

endmodule

`default_nettype wire

// File: hdl/ugpb_dp.sv
// Datapath: configuration registers, bin computation, per-cell and slot memories.
// Depends on ugpb_pkg; sequenced by ugpb_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module ugpb_dp
    import ugpb_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_dp_cmd           i_cmd,
    output t_dp_sts                o_sts,
    input  wire logic [1:0]        i_command,
    input  wire logic [PID_W-1:0]  i_particle_id,
    input  wire logic [POS_W-1:0]  i_pos_x,
    input  wire logic [POS_W-1:0]  i_pos_y,
    input  wire logic [CELL_W-1:0] i_cell_index,
    input  wire logic [PID_W-1:0]  i_slot_index,
    output logic [CNT_W-1:0]       o_cell_start,
    output logic [CNT_W-1:0]       o_cell_end,
    output logic [PID_W-1:0]       o_particle_out,
    output logic [1:0]             o_status,
    input  wire logic              i_cfg_we,
    input  wire logic [1:0]        i_cfg_idx,
    input  wire logic [DATA_W-1:0] i_cfg_wdata,
    output logic [DATA_W-1:0]      o_cfg_rdata
);

    logic [INV_W-1:0]  r_inv;
    logic [SIDE_W-1:0] r_grid;
    logic [CNT_W-1:0]  r_pcnt;
    logic              r_built;
    logic [CNT_W-1:0]  r_cells;

    t_cmd_code         r_s1_cmd;
    t_status           r_s1_sts, n_s1_sts;
    logic [PID_W-1:0]  r_s1_pid;
    logic [SIDE_W-1:0] r_bx, r_by;

    logic [CNT_W-1:0]  r_idx, r_run;
    logic [CELL_W-1:0] r_pc_q, r_cell;
    logic [CNT_W-1:0]  r_cnt_q, r_cur_q, r_first_q;
    logic [PID_W-1:0]  r_sorted_q;

    logic [CELL_W-1:0] mem_pc     [MAX_PARTICLES];
    logic [CNT_W-1:0]  mem_cnt    [MAX_PARTICLES];
    logic [CNT_W-1:0]  mem_first  [MAX_PARTICLES];
    logic [CNT_W-1:0]  mem_cur    [MAX_PARTICLES];
    logic [PID_W-1:0]  mem_sorted [MAX_PARTICLES];

    logic [SIDE_W-1:0]   w_side;
    logic [2*SIDE_W-1:0] w_sq, w_lcell;
    logic [CNT_W-1:0]    w_neff;
    logic [PROD_W-1:0]   w_px, w_py;
    logic [CELL_W-1:0]   w_c, w_idx, w_cnt_ra;
    logic                s1_ok, load_we;
    t_cmd_code           in_cmd;

    always_comb begin
        if (r_grid == '0) w_side = SIDE_W'(1);
        else if (r_grid > SIDE_W'(MAX_GRID_SIDE)) w_side = SIDE_W'(MAX_GRID_SIDE);
        else w_side = r_grid;
        w_sq    = (2*SIDE_W)'(w_side) * (2*SIDE_W)'(w_side);
        w_neff  = (r_pcnt > CNT_W'(MAX_PARTICLES)) ? CNT_W'(MAX_PARTICLES) : r_pcnt;
        w_px    = PROD_W'(i_pos_x) * PROD_W'(r_inv);
        w_py    = PROD_W'(i_pos_y) * PROD_W'(r_inv);
        w_lcell = (2*SIDE_W)'(clamp_bin(r_bx, w_side)) * (2*SIDE_W)'(w_side)
                + (2*SIDE_W)'(clamp_bin(r_by, w_side));
        w_c     = (CNT_W'(r_pc_q) >= r_cells) ? CELL_W'(r_cells - CNT_W'(1)) : r_pc_q;
        w_idx   = r_idx[CELL_W-1:0];
        w_cnt_ra = (i_cmd.phase == ST_CNT_CELL) ? w_c : w_idx;
        s1_ok   = (r_s1_sts == STS_OK);
        load_we = i_cmd.s1_adv && (r_s1_cmd == CMD_LOAD) && s1_ok;
        in_cmd  = t_cmd_code'(i_command);
        case (in_cmd)
            CMD_LOAD:  n_s1_sts = ((PID_W+1)'(i_particle_id) >= (PID_W+1)'(MAX_PARTICLES))
                                  ? STS_RANGE : STS_OK;
            CMD_BUILD: n_s1_sts = STS_OK;
            CMD_CELL:  n_s1_sts = !r_built ? STS_NOT_BUILT :
                                  ((CNT_W'(i_cell_index) >= r_cells) ? STS_RANGE : STS_OK);
            CMD_SLOT:  n_s1_sts = !r_built ? STS_NOT_BUILT :
                                  ((CNT_W'(i_slot_index) >= w_neff) ? STS_RANGE : STS_OK);
            default:   n_s1_sts = STS_OK;
        endcase
        o_sts.s1_build  = (r_s1_cmd == CMD_BUILD);
        o_sts.last_cell = (r_idx == r_cells - CNT_W'(1));
        o_sts.last_part = (r_idx == w_neff - CNT_W'(1));
        o_sts.no_part   = (w_neff == '0);
        case (i_cfg_idx)
            REG_INV:    o_cfg_rdata = DATA_W'(r_inv);
            REG_GRID:   o_cfg_rdata = DATA_W'(r_grid);
            REG_PCOUNT: o_cfg_rdata = DATA_W'(r_pcnt);
            default:    o_cfg_rdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv   <= INV_RST;
            r_grid  <= GRID_RST;
            r_pcnt  <= PCOUNT_RST;
            r_built <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_INV: begin
                        r_inv   <= i_cfg_wdata[INV_W-1:0];
                        r_built <= 1'b0;
                    end
                    REG_GRID: begin
                        r_grid  <= i_cfg_wdata[SIDE_W-1:0];
                        r_built <= 1'b0;
                    end
                    REG_PCOUNT: begin
                        r_pcnt  <= i_cfg_wdata[CNT_W-1:0];
                        r_built <= 1'b0;
                    end
                    default: ;
                endcase
            end else if (i_cmd.accept && in_cmd == CMD_LOAD && n_s1_sts == STS_OK) begin
                r_built <= 1'b0;
            end else if (i_cmd.phase == ST_DONE) begin
                r_built <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cells <= w_sq[CNT_W-1:0];
        if (i_cmd.accept) begin
            r_s1_cmd <= in_cmd;
            r_s1_sts <= n_s1_sts;
            r_s1_pid <= i_particle_id;
            r_bx     <= w_px[PROD_W-1:BIN_SH];
            r_by     <= w_py[PROD_W-1:BIN_SH];
        end
        if (i_cmd.s1_adv) begin
            o_cell_start   <= (r_s1_cmd == CMD_CELL && s1_ok) ? r_first_q : '0;
            o_cell_end     <= (r_s1_cmd == CMD_CELL && s1_ok) ? r_cur_q : '0;
            o_particle_out <= (r_s1_cmd == CMD_SLOT && s1_ok) ? r_sorted_q : '0;
            o_status       <= r_s1_sts;
        end
        if (i_cmd.phase == ST_CNT_CELL || i_cmd.phase == ST_SCT_CELL) r_cell <= w_c;
        case (i_cmd.phase)
            ST_IDLE:   r_idx <= '0;
            ST_CLEAR: begin
                r_run <= '0;
                r_idx <= o_sts.last_cell ? '0 : r_idx + CNT_W'(1);
            end
            ST_PRE_WR: begin
                r_run <= r_run + r_cnt_q;
                r_idx <= o_sts.last_cell ? '0 : r_idx + CNT_W'(1);
            end
            ST_CNT_WR, ST_SCT_WR: r_idx <= o_sts.last_part ? '0 : r_idx + CNT_W'(1);
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (load_we) mem_pc[r_s1_pid] <= w_lcell[CELL_W-1:0];
        if (i_cmd.phase == ST_CNT_RD || i_cmd.phase == ST_SCT_RD) r_pc_q <= mem_pc[w_idx];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.phase == ST_CLEAR) mem_cnt[w_idx] <= '0;
        else if (i_cmd.phase == ST_CNT_WR) mem_cnt[r_cell] <= r_cnt_q + CNT_W'(1);
        if (i_cmd.phase == ST_CNT_CELL || i_cmd.phase == ST_PRE_RD)
            r_cnt_q <= mem_cnt[w_cnt_ra];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.phase == ST_PRE_WR) mem_first[w_idx] <= r_run;
        if (i_cmd.accept) r_first_q <= mem_first[i_cell_index];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.phase == ST_PRE_WR) mem_cur[w_idx] <= r_run;
        else if (i_cmd.phase == ST_SCT_WR) mem_cur[r_cell] <= r_cur_q + CNT_W'(1);
        if (i_cmd.phase == ST_SCT_CELL) r_cur_q <= mem_cur[w_c];
        else if (i_cmd.accept) r_cur_q <= mem_cur[i_cell_index];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.phase == ST_SCT_WR && r_cur_q < CNT_W'(MAX_PARTICLES))
            mem_sorted[r_cur_q[PID_W-1:0]] <= w_idx;
        if (i_cmd.accept) r_sorted_q <= mem_sorted[i_slot_index];
    end

endmodule

`default_nettype wire

// File: hdl/uniform_grid_particle_binning.sv
// Load and query requests are accepted back to back, one per cycle, while no build
// runs and the result side keeps up; each result passes a stage-1 register and then
// a one-entry output register. A build request holds the input while it runs and
// while its result waits: a start state, a clear pass over the side-squared cells,
// a read, cell and write step per particle to count, a read and write step per cell
// for the prefix, the same read, cell and write steps per particle to scatter and a done state.
// A read of a cell or slot returns status 1 until a build follows the last load or
// setting change.
// Top level: ties the interfaces and APB port to ugpb_ctrl and ugpb_dp.
// Depends on ugpb_pkg, ugpb_in_if, ugpb_out_if.
`timescale 1ns / 1ps
`default_nettype none

module uniform_grid_particle_binning
    import ugpb_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    ugpb_in_if.sink                i_item,
    ugpb_out_if.source             o_result,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0]      prdata,
    output logic                   pready
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;
    logic    cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    ugpb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (i_item.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .o_cmd       (dp_cmd),
        .i_sts       (dp_sts)
    );

    ugpb_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_sts          (dp_sts),
        .i_command      (i_item.command),
        .i_particle_id  (i_item.particle_id),
        .i_pos_x        (i_item.pos_x),
        .i_pos_y        (i_item.pos_y),
        .i_cell_index   (i_item.cell_index),
        .i_slot_index   (i_item.slot_index),
        .o_cell_start   (o_result.cell_start),
        .o_cell_end     (o_result.cell_end),
        .o_particle_out (o_result.particle_out),
        .o_status       (o_result.status),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (paddr[3:2]),
        .i_cfg_wdata    (pwdata),
        .o_cfg_rdata    (prdata)
    );

endmodule

`default_nettype wire

// File: tb/tb_uniform_grid_particle_binning.sv
// Self-checking testbench for uniform_grid_particle_binning: loads, builds and
// queries over APB settings, checked against an in-bench counting-sort predictor.
// Depends on ugpb_pkg, ugpb_in_if, ugpb_out_if and the block's RTL.
`timescale 1ns / 1ps

module tb_uniform_grid_particle_binning;
    import ugpb_pkg::*;

    localparam int RAND_ITEMS  = 360;
    localparam int IDLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES = 400;
    localparam int MAX_CELLS   = MAX_GRID_SIDE * MAX_GRID_SIDE;

    typedef struct {
        t_cmd_code        cmd;
        logic [PID_W-1:0] pid;
        logic [POS_W-1:0] px;
        logic [POS_W-1:0] py;
        logic [CELL_W-1:0] cidx;
        logic [PID_W-1:0] sidx;
        bit               fixed;
        t_status          f_sts;
    } t_request;

    typedef struct {
        logic [CNT_W-1:0] start;
        logic [CNT_W-1:0] stop;
        logic [PID_W-1:0] part;
        t_status          sts;
    } t_answer;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic pready;

    ugpb_in_if  item_if();
    ugpb_out_if res_if();

    uniform_grid_particle_binning u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_if),
        .o_result(res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // grid predictor state
    logic [INV_W-1:0]  grid_inv;
    logic [SIDE_W-1:0] grid_dim;
    logic [CNT_W-1:0]  grid_pcount;
    logic [CELL_W-1:0] part_cell [MAX_PARTICLES];
    int                cell_cnt  [MAX_CELLS];
    int                cell_beg  [MAX_CELLS];
    int                cell_cur  [MAX_CELLS];
    logic [PID_W-1:0]  slot_ids  [MAX_PARTICLES];
    bit                grid_built;
    bit                was_loaded [MAX_PARTICLES];

    t_answer pending_results[$];
    int      mismatches = 0;
    int      results_seen = 0;
    int      items_sent = 0;
    int      builds_sent = 0;
    int      burst_left = 0;
    bit      hold_req = 1'b0;
    int      hold_cnt = 0;
    int      idle_cycles = 0;

    function automatic int side_now();
        if (grid_dim < 1) return 1;
        if (grid_dim > MAX_GRID_SIDE) return MAX_GRID_SIDE;
        return int'(grid_dim);
    endfunction

    function automatic int count_now();
        if (grid_pcount > MAX_PARTICLES) return MAX_PARTICLES;
        return int'(grid_pcount);
    endfunction

    function automatic int bin_of(input logic [POS_W-1:0] pos, input int side);
        logic [PROD_W-1:0] prod;
        int b;
        prod = PROD_W'(pos) * PROD_W'(grid_inv);
        b = int'(prod >> BIN_SH);
        return (b >= side) ? side - 1 : b;
    endfunction

    function automatic int stored_cell(input int id, input int cells);
        int c;
        c = int'(part_cell[id]);
        return (c >= cells) ? cells - 1 : c;
    endfunction

    function automatic void run_counting_sort();
        int cells, n, acc, c;
        cells = side_now() * side_now();
        n = count_now();
        acc = 0;
        for (int i = 0; i < cells; i++) cell_cnt[i] = 0;
        for (int i = 0; i < n; i++) cell_cnt[stored_cell(i, cells)]++;
        for (int i = 0; i < cells; i++) begin
            cell_beg[i] = acc;
            cell_cur[i] = acc;
            acc += cell_cnt[i];
        end
        for (int i = 0; i < n; i++) begin
            c = stored_cell(i, cells);
            if (cell_cur[c] < MAX_PARTICLES) slot_ids[cell_cur[c]] = PID_W'(i);
            cell_cur[c]++;
        end
        grid_built = 1'b1;
    endfunction

    function automatic t_answer predict_request(input t_request r);
        t_answer a;
        int side;
        a = '{start: '0, stop: '0, part: '0, sts: STS_OK};
        side = side_now();
        case (r.cmd)
            CMD_LOAD: begin
                part_cell[r.pid] = CELL_W'(bin_of(r.px, side) * side + bin_of(r.py, side));
                was_loaded[r.pid] = 1'b1;
                grid_built = 1'b0;
            end
            CMD_BUILD: run_counting_sort();
            CMD_CELL: begin
                if (!grid_built) a.sts = STS_NOT_BUILT;
                else if (int'(r.cidx) >= side * side) a.sts = STS_RANGE;
                else begin
                    a.start = CNT_W'(cell_beg[r.cidx]);
                    a.stop  = CNT_W'(cell_cur[r.cidx]);
                end
            end
            default: begin
                if (!grid_built) a.sts = STS_NOT_BUILT;
                else if (int'(r.sidx) >= count_now()) a.sts = STS_RANGE;
                else a.part = slot_ids[r.sidx];
            end
        endcase
        return a;
    endfunction

    function automatic t_request mk(input t_cmd_code cmd, input int pid, input int px,
                                    input int py, input int cidx, input int sidx,
                                    input bit fixed = 1'b0, input t_status sts = STS_OK);
        t_request r;
        r.cmd = cmd;
        r.pid = PID_W'(pid);
        r.px = POS_W'(px);
        r.py = POS_W'(py);
        r.cidx = CELL_W'(cidx);
        r.sidx = PID_W'(sidx);
        r.fixed = fixed;
        r.f_sts = sts;
        return r;
    endfunction

    task automatic offer(input t_request r);
        int gap;
        bit took;
        t_answer a;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                item_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        item_if.valid       <= 1'b1;
        item_if.command     <= r.cmd;
        item_if.particle_id <= r.pid;
        item_if.pos_x       <= r.px;
        item_if.pos_y       <= r.py;
        item_if.cell_index  <= r.cidx;
        item_if.slot_index  <= r.sidx;
        do begin
            @(negedge i_clk);
            took = item_if.ready;
            @(posedge i_clk);
        end while (!took);
        a = predict_request(r);
        if (r.fixed) a = '{start: '0, stop: '0, part: '0, sts: r.f_sts};
        pending_results.push_back(a);
        items_sent++;
        if (r.cmd == CMD_BUILD) builds_sent++;
    endtask

    task automatic drain();
        item_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_INV:  grid_inv = INV_W'(value);
            REG_GRID: grid_dim = SIDE_W'(value);
            default:  grid_pcount = CNT_W'(value);
        endcase
        grid_built = 1'b0;
    endtask

    task automatic load_prefix(input int n, input bit all);
        for (int i = 0; i < n; i++)
            if (all || !was_loaded[i])
                offer(mk(CMD_LOAD, i, $urandom_range(0, 65535), $urandom_range(0, 65535), 0, 0));
    endtask

    task automatic random_query(input int cells, input int n);
        if ($urandom_range(0, 1) == 0)
            offer(mk(CMD_CELL, 0, 0, 0, ($urandom_range(0, 3) != 0) ?
                     $urandom_range(0, cells - 1) : $urandom_range(0, 4095), 0));
        else
            offer(mk(CMD_SLOT, 0, 0, 0, 0, ($urandom_range(0, 3) != 0 && n > 0) ?
                     $urandom_range(0, n - 1) : $urandom_range(0, 4095)));
    endtask

    // result side: stall pattern plus one long hold-off
    always @(posedge i_clk) begin
        if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            res_if.ready <= 1'b0;
        end else if (hold_req) begin
            hold_req <= 1'b0;
            hold_cnt <= HOLD_CYCLES;
            res_if.ready <= 1'b0;
        end else begin
            case (($urandom_range(0, 2) == 0) ? 0 : (($time / 2560) % 3))
                0:       res_if.ready <= 1'b1;
                1:       res_if.ready <= ($urandom_range(0, 1) == 0);
                default: res_if.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(negedge i_clk) begin
        t_answer e;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("result with nothing pending");
            end else begin
                e = pending_results.pop_front();
                if (res_if.cell_start !== e.start || res_if.cell_end !== e.stop ||
                    res_if.particle_out !== e.part || res_if.status !== e.sts) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp start %0d end %0d part %0d sts %0d, got %0d %0d %0d %0d",
                                 e.start, e.stop, e.part, e.sts, res_if.cell_start,
                                 res_if.cell_end, res_if.particle_out, res_if.status);
                end
            end
        end
        if ((item_if.valid && item_if.ready) || (res_if.valid && res_if.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL uniform_grid_particle_binning");
            $finish;
        end
    end

    initial begin
        t_request dir_rows[$];
        int side, cells, n, rand_start, pick, phase;
        item_if.valid = 1'b0;
        item_if.command = CMD_LOAD;
        item_if.particle_id = '0;
        item_if.pos_x = '0;
        item_if.pos_y = '0;
        item_if.cell_index = '0;
        item_if.slot_index = '0;
        res_if.ready = 1'b0;
        grid_inv = INV_RST;
        grid_dim = GRID_RST;
        grid_pcount = PCOUNT_RST;
        grid_built = 1'b0;
        for (int i = 0; i < MAX_PARTICLES; i++) was_loaded[i] = 1'b0;
        for (int i = 0; i < MAX_CELLS; i++) cell_cnt[i] = 0;

        dir_rows.push_back(mk(CMD_CELL, 0, 0, 0, 0, 0, 1, STS_NOT_BUILT));
        dir_rows.push_back(mk(CMD_SLOT, 0, 0, 0, 0, 4095, 1, STS_NOT_BUILT));
        dir_rows.push_back(mk(CMD_LOAD, 0, 0, 0, 0, 0, 1, STS_OK));
        dir_rows.push_back(mk(CMD_LOAD, 1, 65535, 65535, 0, 0, 1, STS_OK));
        dir_rows.push_back(mk(CMD_LOAD, 2, 65535, 0, 0, 0, 1, STS_OK));
        dir_rows.push_back(mk(CMD_LOAD, 3, 0, 65535, 0, 0, 1, STS_OK));
        dir_rows.push_back(mk(CMD_LOAD, 4, 32768, 21845, 0, 0, 1, STS_OK));
        dir_rows.push_back(mk(CMD_LOAD, 5, 1, 1, 0, 0, 1, STS_OK));
        dir_rows.push_back(mk(CMD_LOAD, 6, 43690, 43690, 0, 0, 1, STS_OK));
        dir_rows.push_back(mk(CMD_LOAD, 7, 5000, 60000, 0, 0, 1, STS_OK));
        dir_rows.push_back(mk(CMD_BUILD, 0, 0, 0, 0, 0, 1, STS_OK));
        dir_rows.push_back(mk(CMD_CELL, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk(CMD_CELL, 0, 0, 0, 2703, 0));
        dir_rows.push_back(mk(CMD_CELL, 0, 0, 0, 2704, 0, 1, STS_RANGE));
        dir_rows.push_back(mk(CMD_CELL, 0, 0, 0, 4095, 0, 1, STS_RANGE));
        dir_rows.push_back(mk(CMD_SLOT, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk(CMD_SLOT, 0, 0, 0, 0, 7));
        dir_rows.push_back(mk(CMD_SLOT, 0, 0, 0, 0, 8, 1, STS_RANGE));
        dir_rows.push_back(mk(CMD_SLOT, 0, 0, 0, 0, 4095, 1, STS_RANGE));
        dir_rows.push_back(mk(CMD_LOAD, 4095, 12345, 54321, 0, 0, 1, STS_OK));
        dir_rows.push_back(mk(CMD_CELL, 0, 0, 0, 0, 0, 1, STS_NOT_BUILT));
        dir_rows.push_back(mk(CMD_BUILD, 0, 0, 0, 0, 0, 1, STS_OK));
        dir_rows.push_back(mk(CMD_SLOT, 0, 0, 0, 0, 3));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        apb_write(REG_PCOUNT, 8);
        foreach (dir_rows[k]) offer(dir_rows[k]);
        drain();

        // wide pass: oversize grid register, top scale, a few hundred particles
        apb_write(REG_GRID, 127);
        apb_write(REG_INV, 16384);
        apb_write(REG_PCOUNT, 300);
        load_prefix(300, 1'b1);
        offer(mk(CMD_BUILD, 0, 0, 0, 0, 0));
        for (int q = 0; q < 20; q++) random_query(MAX_CELLS, 300);
        drain();

        rand_start = items_sent;
        phase = 0;
        while (items_sent - rand_start < RAND_ITEMS) begin
            drain();
            pick = $urandom_range(0, 5);
            apb_write(REG_INV, (pick == 0) ? 256 : (pick == 1) ? 16384 :
                      (pick == 2) ? 32767 : (pick == 3) ? 0 : $urandom_range(256, 16384));
            if ($urandom_range(0, 2) != 0) begin
                pick = $urandom_range(0, 7);
                apb_write(REG_GRID, (pick == 0) ? 0 : (pick == 1) ? 1 : (pick == 2) ? 64 :
                          (pick == 3) ? 127 : (pick < 6) ? $urandom_range(1, 16) :
                          $urandom_range(1, 64));
            end
            pick = $urandom_range(0, 9);
            apb_write(REG_PCOUNT, (pick == 0) ? 0 : (pick == 1) ? 1 :
                      (pick == 2) ? $urandom_range(1, 200) : $urandom_range(1, 32));
            side = side_now();
            cells = side * side;
            n = count_now();
            load_prefix(n, $urandom_range(0, 1));
            repeat ($urandom_range(0, 3))
                offer(mk(CMD_LOAD, $urandom_range(0, 4095), $urandom_range(0, 65535),
                         $urandom_range(0, 65535), 0, 0));
            if ($urandom_range(0, 7) == 0) random_query(cells, n);
            offer(mk(CMD_BUILD, 0, 0, 0, 0, 0));
            if (phase == 1) begin
                drain();
                burst_left = 60;
                hold_req = 1'b1;
            end
            for (int q = $urandom_range(12, 24); q > 0; q--) begin
                if ($urandom_range(0, 15) == 0) begin
                    offer(mk(CMD_LOAD, $urandom_range(0, 4095), $urandom_range(0, 65535),
                             $urandom_range(0, 65535), 0, 0));
                    random_query(cells, n);
                    offer(mk(CMD_BUILD, 0, 0, 0, 0, 0));
                end
                random_query(cells, n);
            end
            phase++;
        end
        drain();

        $display("covered %0d requests, %0d builds, %0d results over %0d setting phases",
                 items_sent, builds_sent, results_seen, phase + 2);
        $display("mismatches: %0d", mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("PASS uniform_grid_particle_binning");
        else
            $display("FAIL uniform_grid_particle_binning");
        $finish;
    end

endmodule
